/* hw/rtl/adam_pkg.sv */
// shared constants, types and arithmetic step functions of the adam update block
package adam_pkg;

    localparam int FRAC = 24;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;
    localparam logic [23:0] MASK24 = 24'hFFFFFF;
    localparam logic [30:0] MASK31 = 31'h7FFFFFFF;

    localparam logic [23:0] LR_RESET = 24'd16777;
    localparam logic [23:0] B1_RESET = 24'd15099494;
    localparam logic [23:0] B2_RESET = 24'd16760439;

    localparam logic [1:0] REG_LR = 2'd0;
    localparam logic [1:0] REG_B1 = 2'd1;
    localparam logic [1:0] REG_B2 = 2'd2;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_ELEM  = 1'b1;

    // register stages in front of the output register
    localparam int NUM_STAGES = 27;

    typedef struct packed {
        logic [29:0] rem;
        logic [27:0] root;
        logic [55:0] x;
    } sqrt_state_t;

    typedef struct packed {
        logic [28:0] rem;
        logic [55:0] nq;
    } div_state_t;

    typedef struct packed {
        logic in_valid;
        logic busy;
        logic out_ready;
        logic last_elem;
    } pipe_ctl_t;

    // one digit of the restoring square root, two radicand bits a step
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
        logic [31:0] r2;
        logic [31:0] trial;
        sqrt_state_t o;
        r2 = {s.rem, s.x[55:54]};
        trial = {2'b00, s.root, 2'b01};
        o.x = {s.x[53:0], 2'b00};
        if (r2 >= trial) begin
            o.rem = 30'(r2 - trial);
            o.root = {s.root[26:0], 1'b1};
        end else begin
            o.rem = r2[29:0];
            o.root = {s.root[26:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of the restoring divider; a zero divisor gives all ones
    function automatic div_state_t div_step(div_state_t s, logic [28:0] den);
        logic [29:0] r2;
        div_state_t o;
        r2 = {s.rem, s.nq[55]};
        if (r2 >= {1'b0, den}) begin
            o.rem = 29'(r2 - {1'b0, den});
            o.nq = {s.nq[54:0], 1'b1};
        end else begin
            o.rem = r2[28:0];
            o.nq = {s.nq[54:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* hw/rtl/adam_pipe_ctrl.sv */
// valid bits and per-stage load enables of the stallable update pipeline
module adam_pipe_ctrl #(
    parameter int NUM_STAGES = adam_pkg::NUM_STAGES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  adam_pkg::pipe_ctl_t   ctl,
    output logic [NUM_STAGES:0]   ld,
    output logic [NUM_STAGES-1:0] stage_valid,
    output logic                  in_ready,
    output logic                  out_valid
);
    import adam_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NUM_STAGES:0]   rdy;

    always_comb begin
        rdy[NUM_STAGES] = !out_valid_reg || ctl.out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        in_ready = rdy[0] && !ctl.busy;
        ld[0] = ctl.in_valid && in_ready;
        for (int k = 1; k <= NUM_STAGES; k++) begin
            ld[k] = valid_reg[k-1] && rdy[k];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            valid_next[k] = ld[k] || (valid_reg[k] && !rdy[k+1]);
        end
        out_valid_next = (ld[NUM_STAGES] && ctl.last_elem) ||
                         (out_valid_reg && !ctl.out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stage_valid = valid_reg;
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/adam_optimizer_update.sv */
// top level of the streaming fixed-point adam optimizer update
// An element item (tuser = 1) enters every cycle unless a stall or a begin step holds it
// off, and passes an input stage, four stages of multiply and saturate, seven stages of
// square root at four root bits each, one numerator multiply and fourteen divider stages at
// four quotient bits each into the output register. A begin-step item (tuser = 0) runs the
// same stages to produce the new step size and gives no result; no item is accepted until
// it has left the last stage. Configuration writes are taken in every cycle.
module adam_optimizer_update (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // gradient[31:0], first_moment[63:32], second_moment[94:64], weight[126:95], zero[127]
    input  logic [127:0] s_tdata,
    // cmd[0]
    input  logic [0:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_first_moment[31:0], new_second_moment[62:32], new_weight[94:63], zero[95]
    output logic [95:0]  m_tdata
);
    import adam_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // configuration and optimizer state
    logic [23:0] lr_reg, b1_reg, b2_reg;
    logic [24:0] p1_reg, p2_reg;
    logic [23:0] step_reg;
    logic        busy_reg;

    // pipeline control
    logic [NUM_STAGES:0]   ld;
    logic [NUM_STAGES-1:0] stage_valid;
    pipe_ctl_t             ctl;

    // carried fields
    logic        cmd_q [0:LAST];
    logic [31:0] w_q   [0:LAST];
    logic [31:0] mn_q  [2:LAST];
    logic [30:0] vn_q  [4:LAST];
    logic [31:0] mag_q [3:11];
    logic [24:0] d1_q  [2:11];

    // stage 0: input capture
    logic signed [31:0] g0, m0;
    logic [30:0]        v0;
    // stage 1: products
    logic signed [56:0] pm1;
    logic signed [57:0] pg1;
    logic [63:0]        pgg1;
    logic [54:0]        pv1;
    logic [48:0]        pp1_1, pp2_1;
    // stage 2
    logic [38:0]        gsq2;
    logic [54:0]        pv2;
    logic [24:0]        d2_2;
    // stage 3
    logic [48:0]        qlo3;
    logic [39:0]        qhi3;
    logic [54:0]        pv3;
    logic [24:0]        d2_3;
    // stage 4
    logic [55:0]        x4;
    // square root and divider stages
    sqrt_state_t        sq_q  [5:11];
    sqrt_state_t        sq_nx [5:11];
    logic [55:0]        num12;
    logic [28:0]        den12;
    div_state_t         dv_q  [13:LAST];
    div_state_t         dv_nx [13:LAST];
    logic [28:0]        den_q [13:LAST];

    // output register
    logic [31:0] out_mn_reg, out_wn_reg;
    logic [30:0] out_vn_reg;

    // combinational helpers
    logic [24:0]        nb1, nb2;
    logic [31:0]        gabs0;
    logic signed [58:0] msum, mshift;
    logic [31:0]        mn_sat;
    logic [24:0]        np1, np2;
    logic [65:0]        vsum;
    logic [41:0]        vshift;
    logic [30:0]        vn_sat;
    logic [27:0]        root11;
    logic [23:0]        mul_a;
    logic [31:0]        mul_b;
    logic [55:0]        q_last;
    logic signed [57:0] wsum;
    logic [31:0]        wn_sat;
    logic               begin_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= LR_RESET;
            b1_reg <= B1_RESET;
            b2_reg <= B2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LR: lr_reg <= cfg_data;
                REG_B1: b1_reg <= cfg_data;
                REG_B2: b2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ctl.in_valid = s_tvalid;
    assign ctl.busy = busy_reg;
    assign ctl.out_ready = m_tready;
    assign ctl.last_elem = (cmd_q[LAST] == CMD_ELEM);

    adam_pipe_ctrl #(
        .NUM_STAGES(NUM_STAGES)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctl(ctl),
        .ld(ld),
        .stage_valid(stage_valid),
        .in_ready(s_tready),
        .out_valid(m_tvalid)
    );

    assign begin_last = ld[NUM_STAGES] && (cmd_q[LAST] == CMD_BEGIN);

    // a begin step holds off new items until its step size is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ld[0] && (s_tuser[0] == CMD_BEGIN)) begin
            busy_reg <= 1'b1;
        end else if (begin_last) begin
            busy_reg <= 1'b0;
        end
    end

    // decay powers move at stage 2, step size at the pipeline exit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= ONE_Q24;
            p2_reg <= ONE_Q24;
            step_reg <= '0;
        end else begin
            if (ld[2] && (cmd_q[1] == CMD_BEGIN)) begin
                p1_reg <= np1;
                p2_reg <= np2;
            end
            if (begin_last) begin
                step_reg <= (q_last > 56'(MASK24)) ? MASK24 : q_last[23:0];
            end
        end
    end

    // carried fields travel with the load enables
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            cmd_q[0] <= s_tuser[0];
            w_q[0] <= s_tdata[126:95];
        end
        for (int k = 1; k <= LAST; k++) begin
            if (ld[k]) begin
                cmd_q[k] <= cmd_q[k-1];
                w_q[k] <= w_q[k-1];
            end
        end
    end

    // stage 0 and stage 1: operands in, the first round of front-end multiplies
    assign nb1 = ONE_Q24 - {1'b0, b1_reg};
    assign nb2 = ONE_Q24 - {1'b0, b2_reg};
    assign gabs0 = g0[31] ? 32'(-g0) : 32'(g0);

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            g0 <= s_tdata[31:0];
            m0 <= s_tdata[63:32];
            v0 <= s_tdata[94:64];
        end
        if (ld[1]) begin
            pm1 <= $signed({1'b0, b1_reg}) * m0;
            pg1 <= $signed({1'b0, nb1}) * g0;
            pgg1 <= gabs0 * gabs0;
            pv1 <= b2_reg * v0;
            pp1_1 <= p1_reg * b1_reg;
            pp2_1 <= p2_reg * b2_reg;
        end
    end

    // stage 2: first moment with rounding shift and saturation, squared gradient, new powers
    always_comb begin
        msum = 59'(pm1) + 59'(pg1) + 59'sd8388608;
        mshift = msum >>> FRAC;
        if (mshift > 59'sd2147483647) begin
            mn_sat = 32'h7FFFFFFF;
        end else if (mshift < -59'sd2147483648) begin
            mn_sat = 32'h80000000;
        end else begin
            mn_sat = mshift[31:0];
        end
        np1 = 25'((pp1_1 + 49'd8388608) >> FRAC);
        np2 = 25'((pp2_1 + 49'd8388608) >> FRAC);
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            mn_q[2] <= mn_sat;
            gsq2 <= 39'((pgg1 + 64'd8388608) >> FRAC);
            pv2 <= pv1;
            d1_q[2] <= ONE_Q24 - np1;
            d2_2 <= ONE_Q24 - np2;
        end
        for (int k = 3; k <= LAST; k++) begin
            if (ld[k]) mn_q[k] <= mn_q[k-1];
        end
        for (int k = 3; k <= 11; k++) begin
            if (ld[k]) d1_q[k] <= d1_q[k-1];
        end
    end

    // stage 3: second moment products, gradient square split into low and high parts
    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            qlo3 <= nb2 * gsq2[23:0];
            qhi3 <= nb2 * gsq2[38:24];
            pv3 <= pv2;
            mag_q[3] <= mn_q[2][31] ? 32'(-mn_q[2]) : mn_q[2];
            d2_3 <= d2_2;
        end
        for (int k = 4; k <= 11; k++) begin
            if (ld[k]) mag_q[k] <= mag_q[k-1];
        end
    end

    // stage 4: second moment sum and saturation, radicand select
    always_comb begin
        vsum = 66'(pv3) + 66'(qlo3) + (66'(qhi3) << FRAC) + 66'd8388608;
        vshift = 42'(vsum >> FRAC);
        vn_sat = (vshift > 42'(MASK31)) ? MASK31 : vshift[30:0];
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            vn_q[4] <= vn_sat;
            if (cmd_q[3] == CMD_BEGIN) begin
                x4 <= {7'b0, d2_3, 24'b0};
            end else begin
                x4 <= {1'b0, vn_sat, 24'b0};
            end
        end
        for (int k = 5; k <= LAST; k++) begin
            if (ld[k]) vn_q[k] <= vn_q[k-1];
        end
    end

    // stages 5 to 11: square root, four root bits per stage
    always_comb begin
        for (int k = 5; k <= 11; k++) begin
            if (k == 5) begin
                sq_nx[k] = '{rem: '0, root: '0, x: x4};
            end else begin
                sq_nx[k] = sq_q[k-1];
            end
            for (int j = 0; j < 4; j++) begin
                sq_nx[k] = sqrt_step(sq_nx[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 5; k <= 11; k++) begin
            if (ld[k]) sq_q[k] <= sq_nx[k];
        end
    end

    // stage 12: numerator product and divisor
    assign root11 = sq_q[11].root;
    assign mul_a = (cmd_q[11] == CMD_BEGIN) ? lr_reg : step_reg;
    assign mul_b = (cmd_q[11] == CMD_BEGIN) ? {7'b0, root11[24:0]} : mag_q[11];

    always_ff @(posedge aclk) begin
        if (ld[12]) begin
            num12 <= 56'(mul_a * mul_b);
            if (cmd_q[11] == CMD_BEGIN) begin
                den12 <= {4'b0, d1_q[11]};
            end else begin
                den12 <= 29'({1'b0, root11} + 29'd1);
            end
        end
    end

    // stages 13 to the last: divider, four quotient bits per stage
    always_comb begin
        for (int k = 13; k <= LAST; k++) begin
            if (k == 13) begin
                dv_nx[k] = '{rem: '0, nq: num12};
                for (int j = 0; j < 4; j++) begin
                    dv_nx[k] = div_step(dv_nx[k], den12);
                end
            end else begin
                dv_nx[k] = dv_q[k-1];
                for (int j = 0; j < 4; j++) begin
                    dv_nx[k] = div_step(dv_nx[k], den_q[k-1]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 13; k <= LAST; k++) begin
            if (ld[k]) begin
                dv_q[k] <= dv_nx[k];
                if (k == 13) begin
                    den_q[k] <= den12;
                end else begin
                    den_q[k] <= den_q[k-1];
                end
            end
        end
    end

    // exit: weight update with saturation into the output register
    assign q_last = dv_q[LAST].nq;

    always_comb begin
        if (mn_q[LAST][31]) begin
            wsum = 58'($signed(w_q[LAST])) + $signed({2'b0, q_last});
        end else begin
            wsum = 58'($signed(w_q[LAST])) - $signed({2'b0, q_last});
        end
        if (wsum > 58'sd2147483647) begin
            wn_sat = 32'h7FFFFFFF;
        end else if (wsum < -58'sd2147483648) begin
            wn_sat = 32'h80000000;
        end else begin
            wn_sat = wsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[NUM_STAGES] && (cmd_q[LAST] == CMD_ELEM)) begin
            out_mn_reg <= mn_q[LAST];
            out_vn_reg <= vn_q[LAST];
            out_wn_reg <= wn_sat;
        end
    end

    assign m_tdata = {1'b0, out_wn_reg, out_vn_reg, out_mn_reg};

    // no transfer while a begin step is in flight
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input taken during begin step");

    // a begin step in the last stage must still hold the input off
    a_begin_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid[LAST] && (cmd_q[LAST] == CMD_BEGIN)) |-> busy_reg)
        else $error("begin step without busy");

    // decay powers never grow above one
    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_reg <= ONE_Q24) && (p2_reg <= ONE_Q24))
        else $error("decay power above one");

endmodule

/* verif/adam_update_checker.sv */
// checker for the adam update block: predicts each result and compares it
`timescale 1ns / 1ps
module adam_update_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    output int           fail_count,
    output int           pending_count
);
    import adam_pkg::*;

    // highest field first so the first moment lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] w_new;
        logic [30:0]        v_new;
        logic signed [31:0] m_new;
    } adam_result_t;

    logic [63:0] lr_q, b1_q, b2_q, pow1_q, pow2_q, step_q;
    adam_result_t result_fifo[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // element update: new moments and weight
    function automatic adam_result_t adam_element(logic [127:0] d);
        longint g, m, w, acc, mn, wn;
        logic [63:0] v, ga, gsq, vn, den, mag, upd;
        adam_result_t r;
        g = longint'(signed'(d[31:0]));
        m = longint'(signed'(d[63:32]));
        v = {33'd0, d[94:64]};
        w = longint'(signed'(d[126:95]));
        acc = longint'(b1_q) * m + longint'(64'd16777216 - b1_q) * g + 64'sd8388608;
        mn = clamp32(acc >>> 24);
        ga = (g < 0) ? 64'(-g) : 64'(g);
        gsq = (ga * ga + 64'd8388608) >> 24;
        vn = (b2_q * v + (64'd16777216 - b2_q) * gsq + 64'd8388608) >> 24;
        if (vn > 64'h7FFFFFFF) vn = 64'h7FFFFFFF;
        den = int_sqrt(vn << 24) + 1;
        mag = (mn < 0) ? 64'(-mn) : 64'(mn);
        upd = (step_q * mag) / den;
        wn = (mn < 0) ? w + longint'(upd) : w - longint'(upd);
        r.m_new = 32'(mn);
        r.v_new = vn[30:0];
        r.w_new = 32'(clamp32(wn));
        return r;
    endfunction

    assign pending_count = result_fifo.size();

    always @(posedge aclk) begin
        logic [63:0] d1, root, q;
        adam_result_t exp_r, got;
        int errs;
        errs = 0;
        if (!aresetn) begin
            lr_q <= 64'(LR_RESET);
            b1_q <= 64'(B1_RESET);
            b2_q <= 64'(B2_RESET);
            pow1_q = 64'(ONE_Q24);
            pow2_q = 64'(ONE_Q24);
            step_q = 0;
            fail_count <= 0;
            result_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[94:0];
                if (result_fifo.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (got.m_new !== exp_r.m_new) begin
                        $error("new_first_moment exp %0d got %0d", exp_r.m_new, got.m_new);
                        errs++;
                    end
                    if (got.v_new !== exp_r.v_new) begin
                        $error("new_second_moment exp %0d got %0d", exp_r.v_new, got.v_new);
                        errs++;
                    end
                    if (got.w_new !== exp_r.w_new) begin
                        $error("new_weight exp %0d got %0d", exp_r.w_new, got.w_new);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_BEGIN) begin
                    pow1_q = (pow1_q * b1_q + 64'd8388608) >> 24;
                    pow2_q = (pow2_q * b2_q + 64'd8388608) >> 24;
                    d1 = 64'd16777216 - pow1_q;
                    root = int_sqrt((64'd16777216 - pow2_q) << 24);
                    if (d1 == 0) begin
                        step_q = 64'(MASK24);
                    end else begin
                        q = (lr_q * root) / d1;
                        step_q = (q > 64'(MASK24)) ? 64'(MASK24) : q;
                    end
                end else begin
                    result_fifo.push_back(adam_element(s_tdata));
                end
            end
            // config after the item so a same-edge write affects later items only
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LR: lr_q <= 64'(cfg_data);
                    REG_B1: b1_q <= 64'(cfg_data);
                    REG_B2: b2_q <= 64'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

endmodule

/* verif/adam_optimizer_update_tb.sv */
// testbench top: stimulus for the adam update block and the final verdict
`timescale 1ns / 1ps
module adam_optimizer_update_tb;
    import adam_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    bit           quiet_phase = 0;   // no idling on either side near the end

    always #5 aclk = ~aclk;

    adam_optimizer_update DUT (.*);
    adam_update_checker checker_i (.*);

    // receiver stalls in random bursts
    initial begin
        int n;
        wait (aresetn);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one input transfer, with an optional gap burst before it
    task automatic send_item(input logic cmd, input logic [31:0] g, input logic [31:0] m,
                             input logic [30:0] v, input logic [31:0] w);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, w, v, m, g};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        // let the checker record the last transfer first
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        // a trailing begin step may still be in the pipeline
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_val(input int kind);
        case (kind)
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 33554432)) - 16777216);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 49) == 0)
                send_item(CMD_BEGIN, $urandom, $urandom, 31'($urandom), $urandom);
            else
                send_item(CMD_ELEM, rnd_val($urandom_range(0, 9)),
                          rnd_val($urandom_range(0, 9)),
                          ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                              31'($urandom_range(0, 33554432)),
                          rnd_val($urandom_range(0, 9)));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // element before any step: weight passes through
        send_item(CMD_ELEM, 32'h01000000, 32'h00800000, 31'h01000000, 32'h12345678);
        send_item(CMD_ELEM, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(CMD_ELEM, 32'h80000000, 32'h80000000, 31'h0, 32'h80000000);
        send_item(CMD_BEGIN, '0, '0, '0, '0);
        send_item(CMD_ELEM, 32'h80000000, 32'h7FFFFFFF, 31'h0, 32'h80000000);
        send_item(CMD_ELEM, 32'h00000000, 32'h80000000, 31'h0, 32'h7FFFFFFF);
        send_item(CMD_ELEM, 32'hFF000000, 32'h00000001, 31'h1, 32'h0);
        send_item(CMD_BEGIN, $urandom, $urandom, 31'($urandom), $urandom);
        send_item(CMD_ELEM, 32'h00010000, 32'hFFFF0000, 31'h00001000, 32'h01000000);
        // sender holds until every result is back
        drain();

        // extreme decays: zero first decay, max learning rate
        write_reg(REG_LR, MASK24);
        write_reg(REG_B1, 24'd0);
        write_reg(REG_B2, 24'd0);
        send_item(CMD_BEGIN, '0, '0, '0, '0);
        send_item(CMD_ELEM, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 32'h80000000);
        send_item(CMD_ELEM, 32'h80000000, 32'h7FFFFFFF, 31'h0, 32'h7FFFFFFF);
        send_item(CMD_ELEM, 32'h00000001, 32'hFFFFFFFF, 31'h0, 32'h0);
        random_phase(150);
        drain();

        write_reg(REG_LR, 24'd0);
        write_reg(REG_B1, MASK24);
        write_reg(REG_B2, MASK24);
        send_item(CMD_BEGIN, '0, '0, '0, '0);
        random_phase(150);
        drain();

        for (int k = 0; k < 5; k++) begin
            write_reg(REG_LR, 24'($urandom));
            write_reg(REG_B1, 24'($urandom));
            write_reg(REG_B2, 24'($urandom));
            random_phase(250);
            drain();
        end

        write_reg(REG_LR, LR_RESET);
        write_reg(REG_B1, B1_RESET);
        write_reg(REG_B2, B2_RESET);
        random_phase(300);
        quiet_phase = 1;
        random_phase(150);
        drain();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/adam_pkg.sv
hw/rtl/adam_pipe_ctrl.sv
hw/rtl/adam_optimizer_update.sv
verif/adam_update_checker.sv
verif/adam_optimizer_update_tb.sv
